// File: hdl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

    localparam int FREE_ENTRIES = 128;
    localparam int USED_ENTRIES = 128;
    localparam int FW           = $clog2(FREE_ENTRIES);
    localparam int UW           = $clog2(USED_ENTRIES);
    localparam int ENTRY_W      = 64;   // {base, size}

    localparam logic [31:0] LOW_MEM_END   = 32'd655360;
    localparam logic [31:0] GRAIN         = 32'd1024;
    localparam logic [31:0] MAX_ROUNDABLE = 32'hFFFF_FC00;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

    localparam logic [31:0] RST_TOTAL_MEMORY = 32'd16777216;
    localparam logic [19:0] RST_RESERVED_LOW  = 20'd262144;
    localparam logic [20:0] RST_RESERVED_HIGH = 21'd393216;

    typedef enum logic [2:0] {
        KIND_INIT   = 3'd0,
        KIND_ALLOC  = 3'd1,
        KIND_FREE   = 3'd2,
        KIND_RESIZE = 3'd3,
        KIND_MERGE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TOTAL_MEMORY  = 2'd0,
        CFG_RESERVED_LOW  = 2'd1,
        CFG_RESERVED_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT0,
        ST_INIT1,
        ST_FRD,
        ST_FCHK,
        ST_USLOT,
        ST_URD,
        ST_UCHK,
        ST_FSLOT,
        ST_AWR,
        ST_FRWR,
        ST_GROW_WR,
        ST_SHR_WR,
        ST_MI_RD,
        ST_MI_CHK,
        ST_MJ_RD,
        ST_MJ_CHK,
        ST_TOT_F,
        ST_TOT_U,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hdl/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra_if
// Request, response and configuration channels of the region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] byte_count;
    modport source (output valid, kind, address, byte_count, input ready);
    modport sink   (input valid, kind, address, byte_count, output ready);
endinterface

interface ffra_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic        ok;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
    modport source (output valid, block_address, ok, free_bytes, used_bytes, input ready);
    modport sink   (input valid, block_address, ok, free_bytes, used_bytes, output ready);
endinterface

interface ffra_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/ffra_alu.sv
// ----------------------------------------------------------------------------
// ffra_alu
// Shared 32-bit saturating add/subtract unit; the flag is carry or borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_alu (
    input  wire logic             [31:0] i_a,
    input  wire logic             [31:0] i_b,
    input  wire ffra_pkg::t_alu_op       i_op,
    output logic                  [31:0] o_res,
    output logic                         o_flag
);

    logic [32:0] sum;
    logic [32:0] diff;

    assign sum  = {1'b0, i_a} + {1'b0, i_b};
    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        if (i_op == ffra_pkg::ALU_SUB) begin
            o_flag = diff[32];
            o_res  = diff[32] ? 32'd0 : diff[31:0];
        end else begin
            o_flag = sum[32];
            o_res  = sum[32] ? ffra_pkg::ALL_ONES : sum[31:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a free-region table and a used-block table.
// ----------------------------------------------------------------------------
// Each table entry is read through one RAM port with registered read data, so
// every table read has a read state and a check state. One request at a time;
// not ready meanwhile.
// Reset (sync, active low) clears valid bits, totals, the output register
// and returns the configuration registers to their defaults.
`default_nettype none

module first_fit_region_allocator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ffra_req_if.sink        i_req,
    ffra_rsp_if.source      o_rsp,
    ffra_cfg_if.sink        i_cfg
);

    localparam int NF = ffra_pkg::FREE_ENTRIES;
    localparam int NU = ffra_pkg::USED_ENTRIES;
    localparam int FW = ffra_pkg::FW;
    localparam int UW = ffra_pkg::UW;
    localparam int EW = ffra_pkg::ENTRY_W;

    ffra_pkg::t_state r_state, n_state;

    logic [31:0] r_total;
    logic [19:0] r_rlow;
    logic [20:0] r_rhigh;

    logic [NF-1:0] r_fv, n_fv;
    logic [NU-1:0] r_uv, n_uv;

    logic [2:0]    r_kind, n_kind;
    logic [31:0]   r_addr, n_addr;
    logic [31:0]   r_req, n_req;
    logic [31:0]   r_delta, n_delta;
    logic [31:0]   r_end, n_end;
    logic [31:0]   r_fbase, n_fbase;
    logic [31:0]   r_fsize, n_fsize;
    logic [31:0]   r_ubase, n_ubase;
    logic [31:0]   r_usize, n_usize;
    logic [FW-1:0] r_fi, n_fi;
    logic [FW-1:0] r_fj, n_fj;
    logic [UW-1:0] r_ui, n_ui;
    logic [UW-1:0] r_uj, n_uj;
    logic          r_fdec, n_fdec;
    logic          r_merged, n_merged;
    logic          r_ok, n_ok;
    logic [31:0]   r_res, n_res;
    logic [31:0]   r_ft, n_ft;
    logic [31:0]   r_ut, n_ut;

    logic          r_ov, n_ov;
    logic [31:0]   r_o_addr, n_o_addr;
    logic          r_o_ok, n_o_ok;
    logic [31:0]   r_o_fb, n_o_fb;
    logic [31:0]   r_o_ub, n_o_ub;

    // table RAMs
    logic          f_we, u_we;
    logic [FW-1:0] f_waddr, f_raddr;
    logic [UW-1:0] u_waddr, u_raddr;
    logic [EW-1:0] f_wdata, f_rdata, u_wdata, u_rdata;
    logic [31:0]   f_rbase, f_rsize, u_rbase, u_rsize;

    // shared unit
    logic [31:0]       alu_a, alu_b, alu_res;
    ffra_pkg::t_alu_op alu_op;
    logic              alu_flag;

    // request decode
    logic [31:0] cnt_nz, rounded;
    logic        round_ok;
    logic [19:0] r1;
    logic [31:0] r1_32, r2_32, hi, r12;
    logic [32:0] end33;

    ffra_ram #(.WIDTH(EW), .DEPTH(NF)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(f_waddr),
        .i_wdata(f_wdata),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    ffra_ram #(.WIDTH(EW), .DEPTH(NU)) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(u_waddr),
        .i_wdata(u_wdata),
        .i_raddr(u_raddr),
        .o_rdata(u_rdata)
    );

    ffra_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_res (alu_res),
        .o_flag(alu_flag)
    );

    assign f_rbase = f_rdata[63:32];
    assign f_rsize = f_rdata[31:0];
    assign u_rbase = u_rdata[63:32];
    assign u_rsize = u_rdata[31:0];

    assign cnt_nz   = (i_req.byte_count == 32'd0) ? 32'd1 : i_req.byte_count;
    assign round_ok = i_req.byte_count <= ffra_pkg::MAX_ROUNDABLE;
    assign rounded  = (cnt_nz + (ffra_pkg::GRAIN - 32'd1)) & ~(ffra_pkg::GRAIN - 32'd1);

    assign r1    = (r_rlow > ffra_pkg::LOW_MEM_END[19:0]) ? ffra_pkg::LOW_MEM_END[19:0]
                                                          : r_rlow;
    assign r1_32 = {12'd0, r1};
    assign r2_32 = {11'd0, r_rhigh};
    assign hi    = ffra_pkg::LOW_MEM_END + r2_32;
    assign r12   = r1_32 + r2_32;
    assign end33 = {1'b0, f_rbase} + {1'b0, f_rsize};

    assign i_req.ready = (r_state == ffra_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_ov;
    assign o_rsp.block_address = r_o_addr;
    assign o_rsp.ok            = r_o_ok;
    assign o_rsp.free_bytes    = r_o_fb;
    assign o_rsp.used_bytes    = r_o_ub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= ffra_pkg::RST_TOTAL_MEMORY;
            r_rlow  <= ffra_pkg::RST_RESERVED_LOW;
            r_rhigh <= ffra_pkg::RST_RESERVED_HIGH;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                ffra_pkg::CFG_TOTAL_MEMORY:  r_total <= i_cfg.data;
                ffra_pkg::CFG_RESERVED_LOW:  r_rlow  <= i_cfg.data[19:0];
                ffra_pkg::CFG_RESERVED_HIGH: r_rhigh <= i_cfg.data[20:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffra_pkg::ST_IDLE;
            r_fv     <= '0;
            r_uv     <= '0;
            r_ft     <= 32'd0;
            r_ut     <= 32'd0;
            r_ov     <= 1'b0;
            r_merged <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fv     <= n_fv;
            r_uv     <= n_uv;
            r_ft     <= n_ft;
            r_ut     <= n_ut;
            r_ov     <= n_ov;
            r_merged <= n_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_addr   <= n_addr;
        r_req    <= n_req;
        r_delta  <= n_delta;
        r_end    <= n_end;
        r_fbase  <= n_fbase;
        r_fsize  <= n_fsize;
        r_ubase  <= n_ubase;
        r_usize  <= n_usize;
        r_fi     <= n_fi;
        r_fj     <= n_fj;
        r_ui     <= n_ui;
        r_uj     <= n_uj;
        r_fdec   <= n_fdec;
        r_ok     <= n_ok;
        r_res    <= n_res;
        r_o_addr <= n_o_addr;
        r_o_ok   <= n_o_ok;
        r_o_fb   <= n_o_fb;
        r_o_ub   <= n_o_ub;
    end

    always_comb begin
        n_state  = r_state;
        n_fv     = r_fv;
        n_uv     = r_uv;
        n_kind   = r_kind;
        n_addr   = r_addr;
        n_req    = r_req;
        n_delta  = r_delta;
        n_end    = r_end;
        n_fbase  = r_fbase;
        n_fsize  = r_fsize;
        n_ubase  = r_ubase;
        n_usize  = r_usize;
        n_fi     = r_fi;
        n_fj     = r_fj;
        n_ui     = r_ui;
        n_uj     = r_uj;
        n_fdec   = r_fdec;
        n_merged = r_merged;
        n_ok     = r_ok;
        n_res    = r_res;
        n_ft     = r_ft;
        n_ut     = r_ut;
        n_ov     = r_ov && !o_rsp.ready;
        n_o_addr = r_o_addr;
        n_o_ok   = r_o_ok;
        n_o_fb   = r_o_fb;
        n_o_ub   = r_o_ub;

        f_we    = 1'b0;
        f_waddr = r_fi;
        f_wdata = {r_fbase, r_fsize};
        f_raddr = (r_state == ffra_pkg::ST_MJ_RD) ? r_fj : r_fi;
        u_we    = 1'b0;
        u_waddr = r_ui;
        u_wdata = {r_ubase, r_req};
        u_raddr = r_ui;

        alu_a  = 32'd0;
        alu_b  = 32'd0;
        alu_op = ffra_pkg::ALU_ADD;

        unique case (r_state)
            ffra_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = i_req.kind;
                    n_addr   = i_req.address;
                    n_req    = rounded;
                    n_delta  = rounded;
                    n_ok     = 1'b0;
                    n_res    = 32'd0;
                    n_fi     = '0;
                    n_ui     = '0;
                    n_merged = 1'b0;
                    case (i_req.kind)
                        ffra_pkg::KIND_INIT:   n_state = ffra_pkg::ST_INIT0;
                        ffra_pkg::KIND_ALLOC:
                            n_state = round_ok ? ffra_pkg::ST_FRD : ffra_pkg::ST_DONE;
                        ffra_pkg::KIND_FREE:   n_state = ffra_pkg::ST_URD;
                        ffra_pkg::KIND_RESIZE:
                            n_state = round_ok ? ffra_pkg::ST_URD : ffra_pkg::ST_DONE;
                        ffra_pkg::KIND_MERGE:  n_state = ffra_pkg::ST_MI_RD;
                        default:               n_state = ffra_pkg::ST_DONE;
                    endcase
                end
            end

            ffra_pkg::ST_INIT0: begin
                n_fv     = '0;
                n_uv     = '0;
                f_we     = 1'b1;
                f_waddr  = '0;
                f_wdata  = {r1_32, ffra_pkg::LOW_MEM_END - r1_32};
                n_fv[0]  = (ffra_pkg::LOW_MEM_END != r1_32);
                u_we     = 1'b1;
                u_waddr  = '0;
                u_wdata  = {32'd0, r1_32};
                n_uv[0]  = (r1_32 != 32'd0);
                n_state  = ffra_pkg::ST_INIT1;
            end

            ffra_pkg::ST_INIT1: begin
                alu_a   = r_total;
                alu_b   = hi;
                alu_op  = ffra_pkg::ALU_SUB;
                f_we    = 1'b1;
                f_waddr = FW'(1);
                f_wdata = {hi, alu_res};
                n_fv[1] = (alu_res != 32'd0);
                u_we    = 1'b1;
                u_waddr = UW'(1);
                u_wdata = {ffra_pkg::LOW_MEM_END, r2_32};
                n_uv[1] = (r2_32 != 32'd0);
                n_ft    = (r_total > r12) ? (r_total - r12) : 32'd0;
                n_ut    = r12;
                n_ok    = 1'b1;
                n_state = ffra_pkg::ST_DONE;
            end

            ffra_pkg::ST_FRD: n_state = ffra_pkg::ST_FCHK;

            ffra_pkg::ST_FCHK: begin
                // fit test: size - delta must not borrow
                alu_a  = f_rsize;
                alu_b  = r_delta;
                alu_op = ffra_pkg::ALU_SUB;
                if (r_fv[r_fi] && !alu_flag &&
                    (r_kind == ffra_pkg::KIND_ALLOC || f_rbase == r_end)) begin
                    n_fbase = f_rbase;
                    n_fsize = f_rsize;
                    n_uj    = '0;
                    n_state = (r_kind == ffra_pkg::KIND_ALLOC) ? ffra_pkg::ST_USLOT
                                                               : ffra_pkg::ST_GROW_WR;
                end else if (r_fi == FW'(NF - 1)) begin
                    n_state = ffra_pkg::ST_DONE;
                end else begin
                    n_fi    = r_fi + FW'(1);
                    n_state = ffra_pkg::ST_FRD;
                end
            end

            ffra_pkg::ST_USLOT: begin
                if (!r_uv[r_uj]) begin
                    n_state = ffra_pkg::ST_AWR;
                end else if (r_uj == UW'(NU - 1)) begin
                    n_state = ffra_pkg::ST_DONE;
                end else begin
                    n_uj = r_uj + UW'(1);
                end
            end

            ffra_pkg::ST_AWR: begin
                u_we       = 1'b1;
                u_waddr    = r_uj;
                u_wdata    = {r_fbase, r_delta};
                n_uv[r_uj] = 1'b1;
                f_we       = 1'b1;
                f_wdata    = {r_fbase + r_delta, r_fsize - r_delta};
                n_fv[r_fi] = (r_fsize != r_delta);
                n_res      = r_fbase;
                n_ok       = 1'b1;
                n_fdec     = 1'b1;
                n_state    = ffra_pkg::ST_TOT_F;
            end

            ffra_pkg::ST_URD: n_state = ffra_pkg::ST_UCHK;

            ffra_pkg::ST_UCHK: begin
                alu_a  = r_req;
                alu_b  = u_rsize;
                alu_op = ffra_pkg::ALU_SUB;
                if (r_uv[r_ui] && u_rbase == r_addr) begin
                    n_ubase = u_rbase;
                    n_usize = u_rsize;
                    n_fj    = '0;
                    if (r_kind == ffra_pkg::KIND_FREE) begin
                        n_delta = u_rsize;
                        n_state = ffra_pkg::ST_FSLOT;
                    end else if (r_req == u_rsize) begin
                        n_ok    = 1'b1;
                        n_state = ffra_pkg::ST_DONE;
                    end else if (!alu_flag) begin
                        // grow: the block end must be a free region base
                        n_delta = alu_res;
                        n_end   = u_rbase + u_rsize;
                        n_fi    = '0;
                        n_state = ({1'b0, u_rbase} + {1'b0, u_rsize} > {1'b0, ffra_pkg::ALL_ONES})
                                  ? ffra_pkg::ST_DONE : ffra_pkg::ST_FRD;
                    end else begin
                        n_delta = u_rsize - r_req;
                        n_state = ffra_pkg::ST_FSLOT;
                    end
                end else if (r_ui == UW'(NU - 1)) begin
                    n_state = ffra_pkg::ST_DONE;
                end else begin
                    n_ui    = r_ui + UW'(1);
                    n_state = ffra_pkg::ST_URD;
                end
            end

            ffra_pkg::ST_FSLOT: begin
                if (!r_fv[r_fj]) begin
                    n_state = (r_kind == ffra_pkg::KIND_FREE) ? ffra_pkg::ST_FRWR
                                                              : ffra_pkg::ST_SHR_WR;
                end else if (r_fj == FW'(NF - 1)) begin
                    n_state = ffra_pkg::ST_DONE;
                end else begin
                    n_fj = r_fj + FW'(1);
                end
            end

            ffra_pkg::ST_FRWR: begin
                f_we       = 1'b1;
                f_waddr    = r_fj;
                f_wdata    = {r_ubase, r_usize};
                n_fv[r_fj] = 1'b1;
                n_uv[r_ui] = 1'b0;
                n_ok       = 1'b1;
                n_fdec     = 1'b0;
                n_state    = ffra_pkg::ST_TOT_F;
            end

            ffra_pkg::ST_SHR_WR: begin
                u_we       = 1'b1;
                f_we       = 1'b1;
                f_waddr    = r_fj;
                f_wdata    = {r_ubase + r_req, r_delta};
                n_fv[r_fj] = 1'b1;
                n_ok       = 1'b1;
                n_fdec     = 1'b0;
                n_state    = ffra_pkg::ST_TOT_F;
            end

            ffra_pkg::ST_GROW_WR: begin
                u_we       = 1'b1;
                f_we       = 1'b1;
                f_wdata    = {r_fbase + r_delta, r_fsize - r_delta};
                n_fv[r_fi] = (r_fsize != r_delta);
                n_ok       = 1'b1;
                n_fdec     = 1'b1;
                n_state    = ffra_pkg::ST_TOT_F;
            end

            ffra_pkg::ST_TOT_F: begin
                alu_a   = r_ft;
                alu_b   = r_delta;
                alu_op  = r_fdec ? ffra_pkg::ALU_SUB : ffra_pkg::ALU_ADD;
                n_ft    = alu_res;
                n_state = ffra_pkg::ST_TOT_U;
            end

            ffra_pkg::ST_TOT_U: begin
                alu_a   = r_ut;
                alu_b   = r_delta;
                alu_op  = r_fdec ? ffra_pkg::ALU_ADD : ffra_pkg::ALU_SUB;
                n_ut    = alu_res;
                n_state = ffra_pkg::ST_DONE;
            end

            ffra_pkg::ST_MI_RD: n_state = ffra_pkg::ST_MI_CHK;

            ffra_pkg::ST_MI_CHK: begin
                if (r_fv[r_fi] && !end33[32]) begin
                    n_fbase = f_rbase;
                    n_fsize = f_rsize;
                    n_end   = end33[31:0];
                    n_fj    = '0;
                    n_state = ffra_pkg::ST_MJ_RD;
                end else if (r_fi != FW'(NF - 1)) begin
                    n_fi    = r_fi + FW'(1);
                    n_state = ffra_pkg::ST_MI_RD;
                end else if (r_merged) begin
                    n_fi     = '0;
                    n_merged = 1'b0;
                    n_state  = ffra_pkg::ST_MI_RD;
                end else begin
                    n_ok    = 1'b1;
                    n_state = ffra_pkg::ST_DONE;
                end
            end

            ffra_pkg::ST_MJ_RD: n_state = ffra_pkg::ST_MJ_CHK;

            ffra_pkg::ST_MJ_CHK: begin
                alu_a  = r_fsize;
                alu_b  = f_rsize;
                alu_op = ffra_pkg::ALU_ADD;
                if (r_fj != r_fi && r_fv[r_fj] && f_rbase == r_end) begin
                    f_we       = 1'b1;
                    f_wdata    = {r_fbase, alu_res};
                    n_fv[r_fj] = 1'b0;
                    n_merged   = 1'b1;
                end
                if ((r_fj != r_fi && r_fv[r_fj] && f_rbase == r_end) ||
                    r_fj == FW'(NF - 1)) begin
                    // this region is done for the pass
                    if (r_fi != FW'(NF - 1)) begin
                        n_fi    = r_fi + FW'(1);
                        n_state = ffra_pkg::ST_MI_RD;
                    end else if (r_merged || (r_fj != r_fi && r_fv[r_fj] &&
                                              f_rbase == r_end)) begin
                        n_fi     = '0;
                        n_merged = 1'b0;
                        n_state  = ffra_pkg::ST_MI_RD;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = ffra_pkg::ST_DONE;
                    end
                end else begin
                    n_fj    = r_fj + FW'(1);
                    n_state = ffra_pkg::ST_MJ_RD;
                end
            end

            ffra_pkg::ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov     = 1'b1;
                    n_o_addr = r_res;
                    n_o_ok   = r_ok;
                    n_o_fb   = r_ft;
                    n_o_ub   = r_ut;
                    n_state  = ffra_pkg::ST_IDLE;
                end
            end

            default: n_state = ffra_pkg::ST_IDLE;
        endcase
    end

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ok) |-> (o_rsp.block_address == 32'd0))
        else $error("failed response carries a block address");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while a request is in progress");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == ffra_pkg::ST_DONE))
        else $error("response raised outside the completion step");

endmodule

`default_nettype wire

// File: tb/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, response and configuration channels of the region
// allocator. It keeps its own copy of both region tables and the byte totals,
// predicts one result per accepted request and compares it with each
// response transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_checker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ffra_req_if        req,
    ffra_rsp_if        rsp,
    ffra_cfg_if        cfg,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_ok_count
);

    typedef struct packed {
        logic [31:0] block_address;
        logic        ok;
        logic [31:0] free_bytes;
        logic [31:0] used_bytes;
    } t_result;

    t_result     expected_q[$];

    logic [31:0] mem_total;
    logic [19:0] resv_low;
    logic [20:0] resv_high;

    logic [31:0] fr_base [ffra_pkg::FREE_ENTRIES];
    logic [31:0] fr_size [ffra_pkg::FREE_ENTRIES];
    bit          fr_vld  [ffra_pkg::FREE_ENTRIES];
    logic [31:0] ub_base [ffra_pkg::USED_ENTRIES];
    logic [31:0] ub_size [ffra_pkg::USED_ENTRIES];
    bit          ub_vld  [ffra_pkg::USED_ENTRIES];
    logic [31:0] free_sum;
    logic [31:0] used_sum;

    function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ffra_pkg::ALL_ONES : s[31:0];
    endfunction

    // zero counts as one grain; false when the size cannot be rounded
    function automatic bit grain_round(logic [31:0] n, output logic [31:0] r);
        logic [31:0] m;
        r = '0;
        if (n > ffra_pkg::MAX_ROUNDABLE) return 1'b0;
        m = (n == 32'd0) ? 32'd1 : n;
        r = (m + ffra_pkg::GRAIN - 32'd1) & ~(ffra_pkg::GRAIN - 32'd1);
        return 1'b1;
    endfunction

    function automatic int first_empty_free();
        for (int k = 0; k < ffra_pkg::FREE_ENTRIES; k++)
            if (!fr_vld[k]) return k;
        return -1;
    endfunction

    function automatic int lookup_block(logic [31:0] a);
        for (int k = 0; k < ffra_pkg::USED_ENTRIES; k++)
            if (ub_vld[k] && ub_base[k] == a) return k;
        return -1;
    endfunction

    function automatic void wipe_tables();
        for (int k = 0; k < ffra_pkg::FREE_ENTRIES; k++) begin
            fr_base[k] = '0; fr_size[k] = '0; fr_vld[k] = 0;
        end
        for (int k = 0; k < ffra_pkg::USED_ENTRIES; k++) begin
            ub_base[k] = '0; ub_size[k] = '0; ub_vld[k] = 0;
        end
    endfunction

    function automatic void lay_out();
        logic [31:0] r1, r2, hi;
        r1 = ({12'd0, resv_low} > ffra_pkg::LOW_MEM_END) ? ffra_pkg::LOW_MEM_END
                                                         : {12'd0, resv_low};
        r2 = {11'd0, resv_high};
        hi = ffra_pkg::LOW_MEM_END + r2;
        wipe_tables();
        ub_base[0] = 32'd0;       ub_size[0] = r1;  ub_vld[0] = (r1 != 32'd0);
        fr_base[0] = r1;          fr_size[0] = ffra_pkg::LOW_MEM_END - r1;
        fr_vld[0]  = (ffra_pkg::LOW_MEM_END != r1);
        ub_base[1] = ffra_pkg::LOW_MEM_END;
        ub_size[1] = r2;          ub_vld[1] = (r2 != 32'd0);
        fr_base[1] = hi;          fr_size[1] = sub_sat(mem_total, hi);
        fr_vld[1]  = (fr_size[1] != 32'd0);
        free_sum = sub_sat(mem_total, r1 + r2);
        used_sum = r1 + r2;
    endfunction

    function automatic bit carve_block(logic [31:0] n, output logic [31:0] a);
        logic [31:0] want;
        int i, j;
        a = '0;
        if (!grain_round(n, want)) return 1'b0;
        for (i = 0; i < ffra_pkg::FREE_ENTRIES; i++)
            if (fr_vld[i] && fr_size[i] >= want) break;
        if (i >= ffra_pkg::FREE_ENTRIES) return 1'b0;
        for (j = 0; j < ffra_pkg::USED_ENTRIES; j++)
            if (!ub_vld[j]) break;
        if (j >= ffra_pkg::USED_ENTRIES) return 1'b0;
        ub_base[j] = fr_base[i]; ub_size[j] = want; ub_vld[j] = 1;
        fr_base[i] += want;
        fr_size[i] -= want;
        if (fr_size[i] == 32'd0) fr_vld[i] = 0;
        free_sum = sub_sat(free_sum, want);
        used_sum = add_sat(used_sum, want);
        a = ub_base[j];
        return 1'b1;
    endfunction

    function automatic bit release_block(logic [31:0] a);
        int i, j;
        i = lookup_block(a);
        if (i < 0) return 1'b0;
        j = first_empty_free();
        if (j < 0) return 1'b0;
        fr_base[j] = ub_base[i]; fr_size[j] = ub_size[i]; fr_vld[j] = 1;
        ub_vld[i] = 0;
        free_sum = add_sat(free_sum, ub_size[i]);
        used_sum = sub_sat(used_sum, ub_size[i]);
        return 1'b1;
    endfunction

    function automatic bit resize_block(logic [31:0] a, logic [31:0] n);
        logic [31:0] want, old, delta;
        logic [32:0] tail;
        int i, j;
        if (!grain_round(n, want)) return 1'b0;
        i = lookup_block(a);
        if (i < 0) return 1'b0;
        old = ub_size[i];
        if (want == old) return 1'b1;
        if (want > old) begin
            delta = want - old;
            tail  = {1'b0, ub_base[i]} + {1'b0, old};
            if (tail[32]) return 1'b0;
            for (j = 0; j < ffra_pkg::FREE_ENTRIES; j++)
                if (fr_vld[j] && fr_base[j] == tail[31:0] && fr_size[j] >= delta) break;
            if (j >= ffra_pkg::FREE_ENTRIES) return 1'b0;
            ub_size[i] = want;
            fr_base[j] += delta;
            fr_size[j] -= delta;
            if (fr_size[j] == 32'd0) fr_vld[j] = 0;
            free_sum = sub_sat(free_sum, delta);
            used_sum = add_sat(used_sum, delta);
            return 1'b1;
        end
        delta = old - want;
        j = first_empty_free();
        if (j < 0) return 1'b0;
        ub_size[i] = want;
        fr_base[j] = ub_base[i] + want; fr_size[j] = delta; fr_vld[j] = 1;
        free_sum = add_sat(free_sum, delta);
        used_sum = sub_sat(used_sum, delta);
        return 1'b1;
    endfunction

    function automatic void coalesce();
        bit          again;
        logic [32:0] tail;
        again = 1;
        while (again) begin
            again = 0;
            for (int i = 0; i < ffra_pkg::FREE_ENTRIES; i++) begin
                if (!fr_vld[i]) continue;
                tail = {1'b0, fr_base[i]} + {1'b0, fr_size[i]};
                if (tail[32]) continue;
                for (int j = 0; j < ffra_pkg::FREE_ENTRIES; j++) begin
                    if (j != i && fr_vld[j] && fr_base[j] == tail[31:0]) begin
                        fr_size[i] = add_sat(fr_size[i], fr_size[j]);
                        fr_vld[j]  = 0;
                        again = 1;
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic t_result predict_request(logic [2:0] k, logic [31:0] a,
                                                logic [31:0] n);
        t_result r;
        r = '0;
        case (k)
            ffra_pkg::KIND_INIT:   begin lay_out(); r.ok = 1; end
            ffra_pkg::KIND_ALLOC:  r.ok = carve_block(n, r.block_address);
            ffra_pkg::KIND_FREE:   r.ok = release_block(a);
            ffra_pkg::KIND_RESIZE: r.ok = resize_block(a, n);
            ffra_pkg::KIND_MERGE:  begin coalesce(); r.ok = 1; end
            default:               r.ok = 0;
        endcase
        if (!r.ok) r.block_address = '0;
        r.free_bytes = free_sum;
        r.used_bytes = used_sum;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want, got;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            mem_total = ffra_pkg::RST_TOTAL_MEMORY;
            resv_low  = ffra_pkg::RST_RESERVED_LOW;
            resv_high = ffra_pkg::RST_RESERVED_HIGH;
            wipe_tables();
            free_sum = '0;
            used_sum = '0;
            expected_q.delete();
            o_fail_count <= 0;
            o_ok_count   <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    ffra_pkg::CFG_TOTAL_MEMORY:  mem_total = cfg.data;
                    ffra_pkg::CFG_RESERVED_LOW:  resv_low  = cfg.data[19:0];
                    ffra_pkg::CFG_RESERVED_HIGH: resv_high = cfg.data[20:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.block_address, rsp.ok, rsp.free_bytes, rsp.used_bytes};
                if (expected_q.size() == 0) begin
                    $error("response transfer with no request outstanding");
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.ok) o_ok_count <= o_ok_count + 1;
                    if (got.block_address !== want.block_address) begin
                        $error("block_address: expected %h, got %h",
                               want.block_address, got.block_address);
                        errs++;
                    end
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %b, got %b", want.ok, got.ok);
                        errs++;
                    end
                    if (got.free_bytes !== want.free_bytes) begin
                        $error("free_bytes: expected %h, got %h",
                               want.free_bytes, got.free_bytes);
                        errs++;
                    end
                    if (got.used_bytes !== want.used_bytes) begin
                        $error("used_bytes: expected %h, got %h",
                               want.used_bytes, got.used_bytes);
                        errs++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(predict_request(req.kind, req.address,
                                                     req.byte_count));
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_q.size();
    end

endmodule

`default_nettype wire

// File: tb/first_fit_region_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_tb
// Drives the allocator through a directed opening and random request mixes
// under several memory layouts, with bursty requests and a stalling
// response side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator_tb;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int         HOLDOFF_CYCLES   = 3000;
    localparam int         POOL_MAX         = 200;

    logic i_clk;
    logic i_rst_n;

    ffra_req_if req_if ();
    ffra_rsp_if rsp_if ();
    ffra_cfg_if cfg_if ();

    int fail_count, pending, ok_count;
    int sent, burst_left, merges_left, phase_count;
    bit holdoff_req, holdoff_done;
    logic [31:0] addr_pool[$];

    first_fit_region_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    ffra_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .cfg          (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ok_count   (ok_count)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // merges can take many table passes, so the limit is wide
    initial begin
        #500_000_000;
        $display("[first_fit_region_allocator] ERROR");
        $finish;
    end

    // learn block addresses from successful allocations
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready && rsp_if.ok && rsp_if.block_address != 32'd0) begin
            addr_pool.push_back(rsp_if.block_address);
            if (addr_pool.size() > POOL_MAX) void'(addr_pool.pop_front());
        end
    end

    // response side: changing stall pattern plus one long hold-off
    initial begin
        int cyc, mode;
        cyc = 0;
        mode = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 256 == 0) mode = $urandom_range(0, 3);
            if (holdoff_req && !holdoff_done) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_done = 1;
            end else begin
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send(input logic [2:0] k, input logic [31:0] a, input logic [31:0] n);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.kind       <= k;
        req_if.address    <= a;
        req_if.byte_count <= n;
        do @(posedge i_clk); while (!req_if.ready);
        sent++;
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input ffra_pkg::t_cfg_idx idx, input logic [31:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(0, 12000);
        if (r < 8) return $urandom_range(1, 16) << 10;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_addr();
        if (addr_pool.size() == 0 || $urandom_range(0, 6) == 0) return $urandom;
        return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    endfunction

    task automatic random_mix(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      send(ffra_pkg::KIND_ALLOC, $urandom, pick_size());
            else if (r < 62) send(ffra_pkg::KIND_FREE, pick_addr(), $urandom);
            else if (r < 88) send(ffra_pkg::KIND_RESIZE, pick_addr(), pick_size());
            else if (r < 92)
                send(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                     $urandom, $urandom);
            else if (r < 94) send(ffra_pkg::KIND_INIT, $urandom, $urandom);
            else if (merges_left > 0) begin
                merges_left--;
                send(ffra_pkg::KIND_MERGE, $urandom, $urandom);
            end else send(ffra_pkg::KIND_ALLOC, $urandom, pick_size());
        end
    endtask

    task automatic new_layout(input logic [31:0] tot, input logic [31:0] lo,
                              input logic [31:0] hi);
        wait_idle();
        cfg_write(ffra_pkg::CFG_TOTAL_MEMORY, tot);
        cfg_write(ffra_pkg::CFG_RESERVED_LOW, lo);
        cfg_write(ffra_pkg::CFG_RESERVED_HIGH, hi);
        phase_count++;
        merges_left = 3;
        send(ffra_pkg::KIND_INIT, $urandom, $urandom);
    endtask

    initial begin
        logic [31:0] blk;
        sent = 0; burst_left = 0; phase_count = 1; merges_left = 3;
        holdoff_req = 0; holdoff_done = 0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.kind       <= ffra_pkg::KIND_INIT;
        req_if.address    <= '0;
        req_if.byte_count <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= ffra_pkg::CFG_TOTAL_MEMORY;
        cfg_if.data       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening on the reset layout
        send(ffra_pkg::KIND_ALLOC, 32'd0, 32'd4096);          // tables still empty
        send(ffra_pkg::KIND_INIT, 32'd0, 32'd0);
        send(ffra_pkg::KIND_ALLOC, 32'd0, 32'd0);             // 262144, one grain
        send(ffra_pkg::KIND_ALLOC, 32'd0, 32'd1024);          // exact multiple
        send(ffra_pkg::KIND_ALLOC, 32'd0, 32'd1025);          // 264192, two grains
        send(ffra_pkg::KIND_ALLOC, 32'd0, ffra_pkg::MAX_ROUNDABLE);  // nothing fits
        send(ffra_pkg::KIND_ALLOC, 32'd0, ffra_pkg::MAX_ROUNDABLE + 32'd1); // cannot round
        send(ffra_pkg::KIND_ALLOC, 32'd0, ffra_pkg::ALL_ONES);
        send(ffra_pkg::KIND_FREE, 32'h0001_2345, 32'd0);      // unknown block
        send(ffra_pkg::KIND_RESIZE, 32'd264192, 32'd4096);    // grow into neighbor
        send(ffra_pkg::KIND_RESIZE, 32'd264192, 32'd4000);    // same rounded size
        send(ffra_pkg::KIND_RESIZE, 32'd264192, 32'd1);       // shrink, tail freed
        send(ffra_pkg::KIND_RESIZE, 32'd264192, ffra_pkg::ALL_ONES);
        send(ffra_pkg::KIND_RESIZE, 32'd262144, 32'd8192);    // neighbor is used
        send(ffra_pkg::KIND_FREE, 32'd263168, 32'd0);
        send(ffra_pkg::KIND_FREE, 32'd263168, 32'd0);         // already freed
        send(ffra_pkg::KIND_FREE, ffra_pkg::LOW_MEM_END, 32'd0); // reserved high block
        send(ffra_pkg::KIND_MERGE, 32'd0, 32'd0);
        send(ffra_pkg::KIND_ALLOC, 32'd0, 32'd2048);
        send(KIND_SPARE_FIRST, ffra_pkg::ALL_ONES, ffra_pkg::ALL_ONES);
        send(KIND_SPARE_MID, 32'd0, 32'd0);
        send(KIND_SPARE_LAST, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send(ffra_pkg::KIND_RESIZE, 32'h0, 32'd0);            // shrink low reserve
        random_mix(60);

        // huge memory, no reserve: fill the used table, then the free table
        new_layout(ffra_pkg::ALL_ONES, 32'd0, 32'd0);
        addr_pool.delete();
        for (int k = 0; k < 135; k++)
            send(ffra_pkg::KIND_ALLOC, $urandom, $urandom_range(0, 3000));
        wait_idle();
        for (int k = 0; k < 130 && addr_pool.size() > 0; k++) begin
            blk = addr_pool.pop_front();
            send(ffra_pkg::KIND_FREE, blk, $urandom);
        end
        random_mix(40);

        new_layout(32'd1048576, 32'd655360, 32'd1048576);
        holdoff_req = 1;
        random_mix(60);

        new_layout({8'($urandom_range(16, 255)), 24'd0}, 32'hFFF0_0000 | 32'hFFFFF,
                   32'hFFE0_0000 | 32'h1FFFFF);
        random_mix(60);

        new_layout(32'd1048576, $urandom, 32'h1FFFFF);   // free sum saturates
        random_mix(60);

        new_layout($urandom_range(32'd1048576, ffra_pkg::ALL_ONES),
                   $urandom_range(0, 655360), $urandom_range(0, 1048576));
        random_mix(60);

        wait_idle();
        $display("Ran %0d requests over %0d memory layouts; %0d succeeded.",
                 sent, phase_count, ok_count);
        $display("Response side was held off for %0d cycles once mid-run.",
                 HOLDOFF_CYCLES);
        if (fail_count == 0 && holdoff_done)
            $display("[first_fit_region_allocator] OK");
        else
            $display("[first_fit_region_allocator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
